/* rtl/core/fixed_slot_memory_allocator_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fixed slot memory allocator core
// Concurrent check forms used by the core module. Each macro expects
// signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_MEMORY_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_SLOT_MEMORY_ALLOCATOR_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define FSMA_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fsma: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define FSMA_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsma: same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define FSMA_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsma: next-cycle implication violated");

`endif

/* rtl/core/fsma_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed slot allocator package
// Sizes, codes and the structures that travel between the controller and the
// row of slot cells.
// ----------------------------------------------------------------------------
package fsma_pkg;

  // Table size and owner id width.
  localparam int SLOTS   = 4;
  localparam int ID_BITS = 16;

  // Field widths of the channels and the configuration registers.
  localparam int ACT_W      = 2;
  localparam int PID_W      = 16;
  localparam int SLOT_W     = 2;
  localparam int GRANT_W    = 2;
  localparam int USED_W     = 3;
  localparam int TM_W       = 32;
  localparam int SSZ_W      = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Derived internal widths.
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int POS_W  = SSZ_W + $clog2(SLOTS + 1);
  localparam int FRAG_W = ((POS_W > TM_W) ? POS_W : TM_W) + 1;

  // Largest used count that the result field can carry.
  localparam int USED_MAX = (1 << USED_W) - 1;

  // Register reset values.
  localparam logic [TM_W-1:0]  TM_RESET  = TM_W'(16384);
  localparam logic [SSZ_W-1:0] SSZ_RESET = SSZ_W'(4096);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_MEMORY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE    = 1'b1;

  // Request operations.
  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_DEALLOC  = 2'd1,
    ACT_SET_FLAG = 2'd2,
    ACT_QUERY    = 2'd3
  } action_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_APPLY,
    ST_HOLD
  } ctrl_state_t;

  // Request held for the whole walk and broadcast to every cell.
  typedef struct packed {
    action_t              action;
    logic [ID_BITS-1:0]   id;
    logic [SLOT_W-1:0]    slot;
    logic                 flag;
  } req_t;

  // Token handed from cell to cell; it carries the running totals.
  typedef struct packed {
    logic               apply;
    logic               owns;
    logic               taken;
    logic [IDX_W-1:0]   granted;
    logic               present;
    logic [CNT_W-1:0]   used;
    logic               any_free;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   prev_upper;
    logic [FRAG_W-1:0]  frag;
  } tok_t;

  // Result beat payload.
  typedef struct packed {
    logic               success;
    logic [GRANT_W-1:0] granted_slot;
    logic               is_present;
    logic [USED_W-1:0]  used_count;
    logic               any_free;
    logic [TM_W-1:0]    fragmentation;
  } rsp_t;

endpackage

/* rtl/core/fsma_if.sv */
// ----------------------------------------------------------------------------
// Fixed slot allocator channels
// Valid/ready request and response channels of the allocator core.
// ----------------------------------------------------------------------------
interface fsma_req_if;
  import fsma_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [PID_W-1:0]    process_id;
  logic [SLOT_W-1:0]   slot;
  logic                flag_value;

  modport source (output valid, action, process_id, slot, flag_value, input ready);
  modport sink   (input valid, action, process_id, slot, flag_value, output ready);
endinterface

interface fsma_rsp_if;
  import fsma_pkg::*;

  logic                valid;
  logic                ready;
  logic                success;
  logic [GRANT_W-1:0]  granted_slot;
  logic                is_present;
  logic [USED_W-1:0]   used_count;
  logic                any_free;
  logic [TM_W-1:0]     fragmentation;

  modport source (output valid, success, granted_slot, is_present, used_count, any_free,
                  fragmentation, input ready);
  modport sink   (input valid, success, granted_slot, is_present, used_count, any_free,
                  fragmentation, output ready);
endinterface

/* rtl/core/fsma_cell.sv */
// ----------------------------------------------------------------------------
// Fixed slot allocator cell
// Holds one slot's free flag, occupied flag and owner. A passing token is
// updated with this slot's share and registered towards the next cell.
// ----------------------------------------------------------------------------
module fsma_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [fsma_pkg::IDX_W-1:0] cell_idx,
  input  fsma_pkg::req_t             req,
  input  logic [fsma_pkg::SSZ_W-1:0] slot_size,
  input  logic                       vld_in,
  input  fsma_pkg::tok_t             tok_in,
  output logic                       vld_out,
  output fsma_pkg::tok_t             tok_out
);
  import fsma_pkg::*;

  // Slot state.
  logic               free;
  logic               occ;
  logic [ID_BITS-1:0] owner;

  logic               free_next;
  logic               occ_next;
  logic [ID_BITS-1:0] owner_next;

  logic               id_valid;
  logic               match;
  logic               hold_next;
  logic               slot_hit;
  logic [POS_W-1:0]   upper;
  tok_t               tok_next;

  assign id_valid = (req.id != '0);
  assign match    = occ && (owner == req.id) && id_valid;
  assign slot_hit = ((SLOT_W + IDX_W)'(req.slot) == (SLOT_W + IDX_W)'(cell_idx));
  assign upper    = tok_in.pos + POS_W'(slot_size);

  // Lookup pass gathers ownership; apply pass updates the slot and the totals.
  always_comb begin
    free_next  = free;
    occ_next   = occ;
    owner_next = owner;
    tok_next   = tok_in;
    hold_next  = 1'b0;
    if (!tok_in.apply) begin
      tok_next.owns = tok_in.owns | match;
    end else begin
      unique case (req.action)
        ACT_ALLOC: begin
          if (id_valid && !tok_in.owns && !tok_in.taken && free) begin
            free_next        = 1'b0;
            occ_next         = 1'b1;
            owner_next       = req.id;
            tok_next.taken   = 1'b1;
            tok_next.granted = cell_idx;
          end
        end
        ACT_DEALLOC: begin
          if (match) begin
            free_next  = 1'b1;
            occ_next   = 1'b0;
            owner_next = '0;
          end
        end
        ACT_SET_FLAG: begin
          if (slot_hit) begin
            free_next = req.flag;
          end
        end
        ACT_QUERY: begin
          free_next = free;
        end
        default: begin
          free_next = free;
        end
      endcase

      // Totals are taken over the state as it stands after the update.
      hold_next         = occ_next && (owner_next == req.id) && id_valid;
      tok_next.present  = tok_in.present | hold_next;
      tok_next.used     = tok_in.used + CNT_W'(!free_next);
      tok_next.any_free = tok_in.any_free | free_next;
      if (!free_next && occ_next) begin
        if (tok_in.prev_upper < tok_in.pos) begin
          tok_next.frag = tok_in.frag + FRAG_W'(tok_in.pos - tok_in.prev_upper);
        end
        tok_next.prev_upper = upper;
      end
      tok_next.pos = upper;
    end
  end

  // Slot state is written only while the apply pass goes by.
  always_ff @(posedge clk) begin
    if (rst) begin
      free  <= 1'b1;
      occ   <= 1'b0;
      owner <= '0;
    end else if (vld_in && tok_in.apply) begin
      free  <= free_next;
      occ   <= occ_next;
      owner <= owner_next;
    end
  end

  // Token register towards the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

/* rtl/core/fixed_slot_memory_allocator_core.sv */
// ----------------------------------------------------------------------------
// Fixed slot memory allocator core
// First-fit allocator over a row of equal partitions, built as a chain of
// slot cells walked by a token, with the fragmentation figure of the layout.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request beat: action (allocate, deallocate, set free flag,
//   query), process_id, slot and flag_value. rsp returns exactly one result
//   beat per request: success, granted_slot, is_present, used_count, any_free
//   and fragmentation. Both channels move a beat when valid and ready are high.
//   cfg_we with cfg_index and cfg_data writes total_memory or slot_size; write
//   only while no request is in flight.
// Timing:
//   A request walks the cell chain twice, once to look up the owner and once
//   to apply the change and gather the totals, one cell per cycle. The result
//   beat is registered at the output, and req.ready returns in the cycle it
//   becomes valid, so the block takes no new request while one is in flight;
//   the length of the cell chain sets how long each request is in flight.
// Reset and stalls:
//   Reset marks every slot free, unoccupied and without owner and loads the
//   register defaults. A result still waiting at the output does not stop the
//   next request; if it is still there when that one finishes, the new result
//   waits in a holding register and req.ready stays low until the output drains.
// ----------------------------------------------------------------------------
`include "fixed_slot_memory_allocator_core_assert.svh"

module fixed_slot_memory_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsma_pkg::CFG_DATA_W-1:0] cfg_data,
  fsma_req_if.sink                        req,
  fsma_rsp_if.source                      rsp
);
  import fsma_pkg::*;

  // Configuration registers.
  logic [TM_W-1:0]   total_memory;
  logic [SSZ_W-1:0]  slot_size;

  // Controller.
  ctrl_state_t       state;
  ctrl_state_t       state_next;
  req_t              req_q;
  req_t              req_in;
  req_t              req_bc;
  logic              accept;
  logic              load_out;
  logic              capture_fin;
  logic              out_sel_fin;
  logic              out_free;

  // Cell chain.
  logic              launch_vld;
  tok_t              launch_tok;
  logic [SLOTS-1:0]  cell_vld;
  tok_t              cell_tok [SLOTS];
  logic              exit_vld;
  tok_t              exit_tok;

  // Result path.
  rsp_t              res_now;
  rsp_t              fin;
  rsp_t              out_data;
  logic              out_valid;
  logic              tail_lt;
  logic [FRAG_W-1:0] tail;
  logic [FRAG_W-1:0] frag_sum;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_memory <= TM_RESET;
      slot_size    <= SSZ_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TOTAL_MEMORY) begin
        total_memory <= cfg_data[TM_W-1:0];
      end
      if (cfg_index == CFG_SLOT_SIZE) begin
        slot_size <= cfg_data[SSZ_W-1:0];
      end
    end
  end

  // Incoming request, with the owner id cut to its configured width.
  always_comb begin
    req_in.action = action_t'(req.action);
    req_in.id     = ID_BITS'(req.process_id);
    req_in.slot   = req.slot;
    req_in.flag   = req.flag_value;
  end

  // Cells see the incoming request in the cycle of acceptance, the held one after.
  assign req_bc   = (state == ST_IDLE) ? req_in : req_q;
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign exit_vld = cell_vld[SLOTS-1];
  assign exit_tok = cell_tok[SLOTS-1];

  // Controller: next state, token launch and result hand-over.
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    launch_vld  = 1'b0;
    launch_tok  = '0;
    load_out    = 1'b0;
    capture_fin = 1'b0;
    out_sel_fin = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          launch_vld = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (exit_vld) begin
          launch_vld       = 1'b1;
          launch_tok.apply = 1'b1;
          launch_tok.owns  = exit_tok.owns;
          state_next       = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (exit_vld) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            capture_fin = 1'b1;
            state_next  = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_sel_fin = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request held for the whole walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_in;
    end
  end

  // Row of slot cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    fsma_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(i)),
      .req       (req_bc),
      .slot_size (slot_size),
      .vld_in    ((i == 0) ? launch_vld : cell_vld[(i == 0) ? 0 : i - 1]),
      .tok_in    ((i == 0) ? launch_tok : cell_tok[(i == 0) ? 0 : i - 1]),
      .vld_out   (cell_vld[i]),
      .tok_out   (cell_tok[i])
    );
  end

  // Tail gap up to total memory, then saturation to the result width.
  assign tail_lt  = (FRAG_W'(exit_tok.prev_upper) < FRAG_W'(total_memory));
  assign tail     = tail_lt ? (FRAG_W'(total_memory) - FRAG_W'(exit_tok.prev_upper)) : '0;
  assign frag_sum = exit_tok.frag + tail;

  always_comb begin
    res_now = '0;
    unique case (req_q.action)
      ACT_ALLOC:    res_now.success = exit_tok.taken;
      ACT_DEALLOC:  res_now.success = (req_q.id != '0);
      ACT_SET_FLAG: res_now.success = (int'(req_q.slot) < SLOTS);
      ACT_QUERY:    res_now.success = (req_q.id != '0);
      default:      res_now.success = 1'b0;
    endcase
    res_now.granted_slot  = GRANT_W'(exit_tok.granted);
    res_now.is_present    = exit_tok.present;
    res_now.used_count    = (int'(exit_tok.used) > USED_MAX) ? USED_W'(USED_MAX)
                                                              : USED_W'(exit_tok.used);
    res_now.any_free      = exit_tok.any_free;
    res_now.fragmentation = (|frag_sum[FRAG_W-1:TM_W]) ? '1 : frag_sum[TM_W-1:0];
  end

  // Holding register for a result that finds the output still occupied.
  always_ff @(posedge clk) begin
    if (capture_fin) begin
      fin <= res_now;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_sel_fin ? fin : res_now;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.success       = out_data.success;
  assign rsp.granted_slot  = out_data.granted_slot;
  assign rsp.is_present    = out_data.is_present;
  assign rsp.used_count    = out_data.used_count;
  assign rsp.any_free      = out_data.any_free;
  assign rsp.fragmentation = out_data.fragmentation;

  // Only one token may be on the chain at any time.
  `FSMA_ALWAYS(a_single_token, $onehot0(cell_vld))
  // A request is taken only when the chain is empty.
  `FSMA_IMPLY(a_ready_chain_empty, req.ready, cell_vld == '0)
  // A result is held back only because the output register is full.
  `FSMA_IMPLY(a_hold_output_full, state == ST_HOLD, out_valid)
  // After an accepted beat the block is busy.
  `FSMA_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)

endmodule

/* dv/fixed_slot_memory_allocator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fixed slot memory allocator core testbench
// Drives request beats through a randomly idling source, takes result beats
// through a randomly stalling sink, and checks every result against a slot
// table kept alongside the block. Runs a directed opening and then random
// traffic over several total memory and slot size settings.
// ----------------------------------------------------------------------------
module fixed_slot_memory_allocator_core_tb;
  import fsma_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 9;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 188;
  localparam int MAX_WAIT         = 19;
  localparam int ID_POOL          = 6;
  localparam int REPORT_LIMIT     = 10;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int END_GRACE        = 2 * (2 * SLOTS + 1) + 20;

  // Clock, reset and the values driven onto the block's inputs.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic               req_valid = 1'b0;
  req_t               req_bits = '0;
  logic               rsp_ready = 1'b0;

  fsma_req_if req_if();
  fsma_rsp_if rsp_if();

  assign req_if.valid      = req_valid;
  assign req_if.action     = req_bits.action;
  assign req_if.process_id = req_bits.id;
  assign req_if.slot       = req_bits.slot;
  assign req_if.flag_value = req_bits.flag;
  assign rsp_if.ready      = rsp_ready;

  fixed_slot_memory_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mirror of the slot table and of the two registers.
  logic               slot_is_free [SLOTS];
  logic               slot_is_taken[SLOTS];
  logic [ID_BITS-1:0] slot_holder  [SLOTS];
  logic [TM_W-1:0]    mem_total;
  logic [SSZ_W-1:0]   part_size;

  // Requests waiting to be sent, and results owed by the block in order.
  req_t pending_reqs[$];
  rsp_t answers_due[$];

  logic [ID_BITS-1:0] id_pool[ID_POOL];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   served[4] = '{default: 0};
  int   grants = 0;
  logic req_accepted = 1'b0;
  logic rsp_accepted = 1'b0;
  int   send_wait = 0;
  int   stall_left = 0;
  bit   send_quiet = 1'b0;
  bit   stall_quiet = 1'b0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_is_free[i]  = 1'b1;
      slot_is_taken[i] = 1'b0;
      slot_holder[i]   = '0;
    end
    mem_total = TM_RESET;
    part_size = SSZ_RESET;
  end

  // True when a valid id is recorded as owner of an occupied slot.
  function automatic logic id_holds_slot(logic [ID_BITS-1:0] id);
    if (id == '0) return 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_is_taken[i] && slot_holder[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Applies one request to the mirrored table and returns the result it owes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        res;
    logic        found;
    int          used;
    logic [63:0] base, top, prev_top, gaps;
    res   = '0;
    found = 1'b0;
    used  = 0;
    case (r.action)
      ACT_ALLOC: begin
        if (r.id != '0 && !id_holds_slot(r.id)) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && slot_is_free[i]) begin
              found            = 1'b1;
              slot_holder[i]   = r.id;
              slot_is_taken[i] = 1'b1;
              slot_is_free[i]  = 1'b0;
              res.success      = 1'b1;
              res.granted_slot = GRANT_W'(i);
            end
          end
        end
      end
      ACT_DEALLOC: begin
        if (r.id != '0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_is_taken[i] && slot_holder[i] == r.id) begin
              slot_is_taken[i] = 1'b0;
              slot_holder[i]   = '0;
              slot_is_free[i]  = 1'b1;
            end
          end
          res.success = 1'b1;
        end
      end
      ACT_SET_FLAG: begin
        if (int'(r.slot) < SLOTS) begin
          slot_is_free[r.slot] = r.flag;
          res.success          = 1'b1;
        end
      end
      default: res.success = (r.id != '0);
    endcase

    for (int i = 0; i < SLOTS; i++) begin
      if (slot_is_free[i]) res.any_free = 1'b1;
      else used++;
    end
    res.used_count = USED_W'((used > USED_MAX) ? USED_MAX : used);
    res.is_present = id_holds_slot(r.id);

    // Gaps between slots that are both in use and owned, then the tail.
    prev_top = '0;
    gaps     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_is_free[i] && slot_is_taken[i]) begin
        base = 64'(i) * 64'(part_size);
        top  = base + 64'(part_size);
        if (prev_top < base) gaps += base - prev_top;
        prev_top = top;
      end
    end
    if (prev_top < 64'(mem_total)) gaps += 64'(mem_total) - prev_top;
    res.fragmentation = (gaps > 64'hFFFF_FFFF) ? '1 : gaps[TM_W-1:0];
    return res;
  endfunction

  // Idle length for one beat; now and then a side switches to a stretch of
  // back-to-back beats and back again.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic void push_req(action_t a, logic [ID_BITS-1:0] id,
                                   logic [SLOT_W-1:0] s, logic f);
    req_t r;
    r.action = a;
    r.id     = id;
    r.slot   = s;
    r.flag   = f;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Random request: mostly ids from a small pool so that allocations,
  // releases and queries meet each other, with some id zero and stray ids.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      r.action = ACT_ALLOC;
    else if (pick < 60) r.action = ACT_DEALLOC;
    else if (pick < 75) r.action = ACT_SET_FLAG;
    else                r.action = ACT_QUERY;
    pick = $urandom_range(0, 99);
    if (pick < 6)       r.id = '0;
    else if (pick < 84) r.id = id_pool[$urandom_range(0, ID_POOL - 1)];
    else                r.id = ID_BITS'($urandom);
    r.slot = SLOT_W'($urandom);
    r.flag = 1'($urandom);
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endfunction

  // Register write, issued only while nothing is in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOTAL_MEMORY) mem_total = data[TM_W-1:0];
    else                         part_size = data[SSZ_W-1:0];
  endtask

  // Request source: holds a beat until it is taken, then idles a drawn
  // number of cycles before offering the next one.
  always @(negedge clk) begin
    req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      send_wait = draw_wait(send_quiet);
    end else if (req_valid && !req_accepted) begin
      // Beat still on offer.
    end else if (send_wait > 0) begin
      send_wait--;
      req_valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      nxt = pending_reqs.pop_front();
      req_bits  <= nxt;
      req_valid <= 1'b1;
      send_wait = draw_wait(send_quiet);
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Result sink: after each taken beat, ready drops for a drawn stall.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left = draw_wait(stall_quiet);
    end else begin
      if (rsp_accepted) stall_left = draw_wait(stall_quiet);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks result beats against the oldest owed result, then
  // predicts the result of any request beat taken at the same edge.
  always @(posedge clk) begin
    req_t seen;
    rsp_t want;
    cycle_count  <= cycle_count + 1;
    req_accepted <= !rst && req_if.valid && req_if.ready;
    rsp_accepted <= !rst && rsp_if.valid && rsp_if.ready;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (answers_due.size() == 0) begin
          note_failure("result beat with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          check_field("success", 32'(want.success), 32'(rsp_if.success));
          check_field("granted_slot", 32'(want.granted_slot), 32'(rsp_if.granted_slot));
          check_field("is_present", 32'(want.is_present), 32'(rsp_if.is_present));
          check_field("used_count", 32'(want.used_count), 32'(rsp_if.used_count));
          check_field("any_free", 32'(want.any_free), 32'(rsp_if.any_free));
          check_field("fragmentation", want.fragmentation, rsp_if.fragmentation);
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.action = action_t'(req_if.action);
        seen.id     = req_if.process_id;
        seen.slot   = req_if.slot;
        seen.flag   = req_if.flag_value;
        want = apply_request(seen);
        answers_due.insert(answers_due.size(), want);
        served[seen.action]++;
        if (seen.action == ACT_ALLOC && want.success) grants++;
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
             answers_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus: reset, then one phase per register setting.
  initial begin
    logic [TM_W-1:0]  tm_val;
    logic [SSZ_W-1:0] ssz_val;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      tm_val  = TM_RESET;
      ssz_val = SSZ_RESET;
      case (phase)
        1: begin
          tm_val  = '1;
          ssz_val = '1;
        end
        2: begin
          tm_val  = '0;
          ssz_val = SSZ_W'(1);
        end
        3: begin
          tm_val  = TM_W'($urandom);
          ssz_val = '0;
        end
        4: begin
          ssz_val = SSZ_W'($urandom_range(1, 1 << 20));
          tm_val  = TM_W'($urandom_range(0, 5 * int'(ssz_val)));
        end
        5: begin
          tm_val  = TM_W'(1);
          ssz_val = SSZ_W'(1 << 20);
        end
        default: ;
      endcase
      // High data bits above the slot size field should be dropped.
      if (phase > 0) begin
        write_reg(CFG_TOTAL_MEMORY, tm_val);
        write_reg(CFG_SLOT_SIZE, {11'($urandom), ssz_val});
      end

      for (int k = 0; k < ID_POOL; k++) id_pool[k] = ID_BITS'($urandom_range(1, 65535));

      if (phase == 0) begin
        // Id zero is refused by every id-based action.
        push_req(ACT_ALLOC, '0, 2'd3, 1'b1);
        push_req(ACT_DEALLOC, '0, 2'd2, 1'b0);
        push_req(ACT_QUERY, '0, 2'd1, 1'b1);
        // Fill the table; a second allocate by the same owner fails, and so
        // does one with no free slot left.
        push_req(ACT_ALLOC, 16'hFFFF, 2'd0, 1'b0);
        push_req(ACT_ALLOC, 16'hFFFF, 2'd1, 1'b1);
        push_req(ACT_ALLOC, 16'h5555, 2'd2, 1'b0);
        push_req(ACT_ALLOC, 16'hAAAA, 2'd3, 1'b1);
        push_req(ACT_ALLOC, 16'h0001, 2'd0, 1'b0);
        push_req(ACT_ALLOC, 16'h0002, 2'd1, 1'b1);
        push_req(ACT_QUERY, 16'h5555, 2'd0, 1'b0);
        push_req(ACT_QUERY, 16'h0002, 2'd3, 1'b1);
        // Freeing a slot by flag leaves its owner; the next allocate takes
        // it over and the previous owner disappears.
        push_req(ACT_SET_FLAG, 16'h1234, 2'd1, 1'b1);
        push_req(ACT_ALLOC, 16'h0002, 2'd2, 1'b0);
        push_req(ACT_QUERY, 16'h5555, 2'd1, 1'b1);
        // Releasing an id that owns nothing still succeeds.
        push_req(ACT_DEALLOC, 16'h1234, 2'd0, 1'b1);
        // Free but occupied slots drop out of the fragmentation figure.
        push_req(ACT_SET_FLAG, 16'h0000, 2'd3, 1'b1);
        push_req(ACT_SET_FLAG, 16'hFFFF, 2'd3, 1'b0);
        push_req(ACT_SET_FLAG, 16'h8000, 2'd0, 1'b0);
        // A slot marked in use without an owner counts as used only.
        push_req(ACT_DEALLOC, 16'hFFFF, 2'd3, 1'b0);
        push_req(ACT_SET_FLAG, 16'h7FFF, 2'd0, 1'b0);
        push_req(ACT_DEALLOC, 16'hAAAA, 2'd1, 1'b1);
        push_req(ACT_DEALLOC, 16'h0002, 2'd2, 1'b0);
        push_req(ACT_DEALLOC, 16'h0001, 2'd3, 1'b1);
        push_req(ACT_SET_FLAG, 16'hFFFF, 2'd0, 1'b1);
      end

      repeat (RANDOM_PER_PHASE) pending_reqs.insert(pending_reqs.size(), random_request());

      while (pending_reqs.size() != 0 || req_valid || answers_due.size() != 0)
        @(negedge clk);
    end

    // Catch any late or extra result beat.
    repeat (END_GRACE) @(negedge clk);

    $display("Sent %0d requests: %0d allocate (%0d granted), %0d deallocate, %0d set-flag,",
             served[ACT_ALLOC] + served[ACT_DEALLOC] + served[ACT_SET_FLAG]
             + served[ACT_QUERY], served[ACT_ALLOC], grants, served[ACT_DEALLOC],
             served[ACT_SET_FLAG]);
    $display("%0d query, over %0d register settings; %0d mismatches", served[ACT_QUERY],
             PHASES, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
